@@ src/triangle_tangent_normal_setup_defines.svh @@
// Assertion macros for the triangle tangent/normal setup block.
// Used by triangle_tangent_normal_setup.sv; expects clk and arst_n in scope.
`ifndef TRIANGLE_TANGENT_NORMAL_SETUP_DEFINES_SVH
`define TRIANGLE_TANGENT_NORMAL_SETUP_DEFINES_SVH

// same-cycle implication
`define TTNS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ttns: same-cycle check failed");

// next-cycle implication
`define TTNS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ttns: next-cycle check failed");

`endif

@@ src/ttns_pkg.sv @@
// Shared types and constants for the triangle tangent/normal setup block.
// No dependencies.
package ttns_pkg;

	localparam int POS_W   = 32;
	localparam int UV_W    = 24;
	localparam int THR_W   = 47;
	localparam int EDGE_W  = 33;
	localparam int DUV_W   = 25;
	localparam int DET_W   = 52;
	localparam int CW      = 68;
	localparam int MAG_W   = 67;
	localparam int NORM_B  = 30;
	localparam int OUT_W   = 18;
	localparam int DIV_W   = 47;

	localparam logic [5:0] MUL_LAST = 6'd32;
	localparam logic [5:0] DIV_LAST = 6'd46;
	localparam logic [OUT_W-1:0] UNIT_ONE = 18'd65536;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_LOAD  = 12'b0000_0000_0010,
		ST_MUL   = 12'b0000_0000_0100,
		ST_ACC   = 12'b0000_0000_1000,
		ST_DET   = 12'b0000_0001_0000,
		ST_ABS   = 12'b0000_0010_0000,
		ST_SHIFT = 12'b0000_0100_0000,
		ST_SQRT  = 12'b0000_1000_0000,
		ST_LEN   = 12'b0001_0000_0000,
		ST_DIV   = 12'b0010_0000_0000,
		ST_STORE = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [3:0] {
		OP_DET0 = 4'd0,  OP_DET1 = 4'd1,
		OP_TX0  = 4'd2,  OP_TX1  = 4'd3,
		OP_TY0  = 4'd4,  OP_TY1  = 4'd5,
		OP_TZ0  = 4'd6,  OP_TZ1  = 4'd7,
		OP_NX0  = 4'd8,  OP_NX1  = 4'd9,
		OP_NY0  = 4'd10, OP_NY1  = 4'd11,
		OP_NZ0  = 4'd12, OP_NZ1  = 4'd13
	} op_t;

	typedef struct packed {
		logic              neg;
		logic [EDGE_W-1:0] a;
		logic [EDGE_W-1:0] b;
	} mul_ld_t;

endpackage

@@ src/triangle_tangent_normal_setup.sv @@
// Triangle tangent/normal setup: top level, single module.
// Depends on ttns_pkg and triangle_tangent_normal_setup_defines.svh.
//
// Takes one vertex per request as a triangle list and returns one result per third vertex:
// unit tangent and unit face normal in Q1.16 with two degeneracy flags. Work is done by one
// shift-add multiplier, one bit-serial square root and one restoring divider, all sharing a
// sequencer; the first two vertices of a triangle are only stored, while the third occupies
// the block for up to 14 products plus up to two normalizations (shift search, three
// squares, 32 root steps, three 47-step divides). s_axis_tready is low while that work
// runs. A finished result waits in the output register while the next triangle's vertices
// are taken.
module triangle_tangent_normal_setup (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata,  // tan_x, tan_y, tan_z, nrm_x, nrm_y, nrm_z, pad
	output logic [1:0]   m_axis_tuser,  // uv_degenerate, area_degenerate
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [46:0]  cfg_data       // uv_det_threshold
);

`include "triangle_tangent_normal_setup_defines.svh"

	ttns_pkg::state_t state_q;
	ttns_pkg::op_t    op_q;
	logic [1:0]       slot_q;
	logic [46:0]      thr_q;

	logic signed [31:0] p0_q [3];
	logic signed [31:0] p1_q [3];
	logic signed [23:0] t0_q [2];
	logic signed [23:0] t1_q [2];
	logic signed [32:0] e1_q [3];
	logic signed [32:0] e2_q [3];
	logic signed [24:0] du1_q, dv1_q, du2_q, dv2_q;

	logic [65:0] mul_a_q;
	logic [32:0] mul_b_q;
	logic        mul_neg_q;
	logic [65:0] mul_p_q;
	logic [5:0]  cnt_q;
	logic        sq_mode_q;
	logic [1:0]  idx_q;

	logic signed [67:0] acc_q;
	logic signed [51:0] det_q;
	logic signed [67:0] c_q [3];
	logic               det_neg_q, uv_deg_q, area_deg_q, vec_nrm_q;

	logic        nneg_q [3];
	logic [66:0] m_q [3];
	logic [61:0] sum_q;
	logic [62:0] sq_rem_q, sq_res_q, sq_bit_q;
	logic [30:0] len_q;
	logic [46:0] dnum_q;
	logic [31:0] drem_q;
	logic [17:0] quo_q;

	logic signed [17:0] tan_q [3];
	logic signed [17:0] nrm_q [3];

	logic         o_valid_q;
	logic [111:0] o_data_q;
	logic [1:0]   o_user_q;

	logic signed [31:0] in_p [3];
	logic signed [23:0] in_t [2];
	logic               in_acc;

	assign in_p[0] = s_axis_tdata[31:0];
	assign in_p[1] = s_axis_tdata[63:32];
	assign in_p[2] = s_axis_tdata[95:64];
	assign in_t[0] = s_axis_tdata[119:96];
	assign in_t[1] = s_axis_tdata[143:120];

	assign s_axis_tready = (state_q == ttns_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata  = o_data_q;
	assign m_axis_tuser  = o_user_q;

	function automatic ttns_pkg::mul_ld_t mul_ld(input ttns_pkg::op_t op);
		logic signed [32:0] a;
		logic signed [32:0] b;
		ttns_pkg::mul_ld_t  r;
		case (op)
			ttns_pkg::OP_DET0: begin a = 33'(du1_q);  b = 33'(dv2_q);  end
			ttns_pkg::OP_DET1: begin a = 33'(du2_q);  b = 33'(dv1_q);  end
			ttns_pkg::OP_TX0:  begin a = 33'(dv2_q);  b = e1_q[0];     end
			ttns_pkg::OP_TX1:  begin a = 33'(dv1_q);  b = e2_q[0];     end
			ttns_pkg::OP_TY0:  begin a = 33'(dv2_q);  b = e1_q[1];     end
			ttns_pkg::OP_TY1:  begin a = 33'(dv1_q);  b = e2_q[1];     end
			ttns_pkg::OP_TZ0:  begin a = 33'(dv2_q);  b = e1_q[2];     end
			ttns_pkg::OP_TZ1:  begin a = 33'(dv1_q);  b = e2_q[2];     end
			ttns_pkg::OP_NX0:  begin a = e1_q[1];     b = e2_q[2];     end
			ttns_pkg::OP_NX1:  begin a = e1_q[2];     b = e2_q[1];     end
			ttns_pkg::OP_NY0:  begin a = e1_q[2];     b = e2_q[0];     end
			ttns_pkg::OP_NY1:  begin a = e1_q[0];     b = e2_q[2];     end
			ttns_pkg::OP_NZ0:  begin a = e1_q[0];     b = e2_q[1];     end
			ttns_pkg::OP_NZ1:  begin a = e1_q[1];     b = e2_q[0];     end
			default:           begin a = '0;          b = '0;          end
		endcase
		r.neg = a[32] ^ b[32];
		r.a   = a[32] ? 33'(-a) : 33'(a);
		r.b   = b[32] ? 33'(-b) : 33'(b);
		return r;
	endfunction

	ttns_pkg::mul_ld_t  ld_c;
	logic signed [67:0] prod_c, diff_c, sdiff_c;
	logic [51:0]        det_mag_c;
	logic               uv_small_c;
	logic [62:0]        sq_try_c;
	logic               sq_ge_c;
	logic [31:0]        div_r_c;
	logic               div_ge_c;
	logic [1:0]         dsel_c;
	logic [30:0]        len_c;
	logic [46:0]        div_num_c;
	logic [66:0]        mor_c;
	logic [17:0]        qval_c;
	logic [61:0]        sum_nxt_c;
	logic [1:0]         cidx_c;
	logic               len_zero_c;

	always_comb begin
		if (sq_mode_q) begin
			ld_c.neg = 1'b0;
			ld_c.a   = {3'b0, m_q[idx_q][29:0]};
			ld_c.b   = {3'b0, m_q[idx_q][29:0]};
		end else begin
			ld_c = mul_ld(op_q);
		end
	end

	assign prod_c     = mul_neg_q ? -$signed({2'b0, mul_p_q}) : $signed({2'b0, mul_p_q});
	assign diff_c     = acc_q - prod_c;
	assign sdiff_c    = det_neg_q ? -diff_c : diff_c;
	assign det_mag_c  = det_q[51] ? 52'(-det_q) : 52'(det_q);
	assign uv_small_c = !(det_mag_c > {5'b0, thr_q});
	assign sq_try_c   = sq_res_q + sq_bit_q;
	assign sq_ge_c    = sq_rem_q >= sq_try_c;
	assign div_r_c    = {drem_q[30:0], dnum_q[46]};
	assign div_ge_c   = div_r_c >= {1'b0, len_q};
	assign dsel_c     = (state_q == ttns_pkg::ST_LEN) ? 2'd0 : 2'(idx_q + 2'd1);
	assign len_c      = (state_q == ttns_pkg::ST_LEN) ? sq_res_q[30:0] : len_q;
	assign div_num_c  = {1'b0, m_q[dsel_c][29:0], 16'b0} + 47'(len_c >> 1);
	assign mor_c      = m_q[0] | m_q[1] | m_q[2];
	assign qval_c     = nneg_q[idx_q] ? 18'(-quo_q) : quo_q;
	assign sum_nxt_c  = sum_q + {2'b0, mul_p_q[59:0]};
	assign cidx_c     = vec_nrm_q ? op_q[2:1] : 2'(op_q[2:1] - 2'd1);
	assign len_zero_c = (sq_res_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ttns_pkg::ST_IDLE;
			op_q      <= ttns_pkg::OP_DET0;
			slot_q    <= '0;
			thr_q     <= '0;
			o_valid_q <= 1'b0;
			sq_mode_q <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
			vec_nrm_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				p0_q[i] <= '0;
				p1_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				t0_q[i] <= '0;
				t1_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready)
				thr_q <= cfg_data;
			if (o_valid_q && m_axis_tready && state_q != ttns_pkg::ST_DONE)
				o_valid_q <= 1'b0;

			case (state_q)
				ttns_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (slot_q == 2'd1) begin
							for (int i = 0; i < 3; i++) p1_q[i] <= in_p[i];
							for (int i = 0; i < 2; i++) t1_q[i] <= in_t[i];
							slot_q <= 2'd2;
						end else if (slot_q == 2'd2) begin
							for (int i = 0; i < 3; i++) begin
								e1_q[i] <= 33'(p1_q[i]) - 33'(p0_q[i]);
								e2_q[i] <= 33'(in_p[i]) - 33'(p0_q[i]);
							end
							du1_q     <= 25'(t1_q[0]) - 25'(t0_q[0]);
							dv1_q     <= 25'(t1_q[1]) - 25'(t0_q[1]);
							du2_q     <= 25'(in_t[0]) - 25'(t0_q[0]);
							dv2_q     <= 25'(in_t[1]) - 25'(t0_q[1]);
							slot_q    <= 2'd0;
							op_q      <= ttns_pkg::OP_DET0;
							sq_mode_q <= 1'b0;
							vec_nrm_q <= 1'b0;
							state_q   <= ttns_pkg::ST_LOAD;
						end else begin
							for (int i = 0; i < 3; i++) p0_q[i] <= in_p[i];
							for (int i = 0; i < 2; i++) t0_q[i] <= in_t[i];
							slot_q <= 2'd1;
						end
					end
				end
				ttns_pkg::ST_LOAD: begin
					mul_a_q   <= {33'b0, ld_c.a};
					mul_b_q   <= ld_c.b;
					mul_neg_q <= ld_c.neg;
					mul_p_q   <= '0;
					cnt_q     <= ttns_pkg::MUL_LAST;
					state_q   <= ttns_pkg::ST_MUL;
				end
				ttns_pkg::ST_MUL: begin
					if (mul_b_q[0])
						mul_p_q <= mul_p_q + mul_a_q;
					mul_a_q <= mul_a_q << 1;
					mul_b_q <= mul_b_q >> 1;
					cnt_q   <= cnt_q - 6'd1;
					if (cnt_q == '0)
						state_q <= ttns_pkg::ST_ACC;
				end
				ttns_pkg::ST_ACC: begin
					if (sq_mode_q) begin
						sum_q <= sum_nxt_c;
						if (idx_q == 2'd2) begin
							sq_rem_q <= {1'b0, sum_nxt_c};
							sq_res_q <= '0;
							sq_bit_q <= 63'(1) << 62;
							state_q  <= ttns_pkg::ST_SQRT;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ttns_pkg::ST_LOAD;
						end
					end else if (!op_q[0]) begin
						acc_q   <= prod_c;
						op_q    <= ttns_pkg::op_t'(op_q + 4'd1);
						state_q <= ttns_pkg::ST_LOAD;
					end else if (op_q == ttns_pkg::OP_DET1) begin
						det_q   <= diff_c[51:0];
						state_q <= ttns_pkg::ST_DET;
					end else begin
						c_q[cidx_c] <= vec_nrm_q ? diff_c : sdiff_c;
						if (op_q == ttns_pkg::OP_TZ1 || op_q == ttns_pkg::OP_NZ1) begin
							state_q <= ttns_pkg::ST_ABS;
						end else begin
							op_q    <= ttns_pkg::op_t'(op_q + 4'd1);
							state_q <= ttns_pkg::ST_LOAD;
						end
					end
				end
				ttns_pkg::ST_DET: begin
					det_neg_q <= det_q[51];
					uv_deg_q  <= uv_small_c;
					if (uv_small_c) begin
						tan_q[0]  <= ttns_pkg::UNIT_ONE;
						tan_q[1]  <= '0;
						tan_q[2]  <= '0;
						op_q      <= ttns_pkg::OP_NX0;
						vec_nrm_q <= 1'b1;
					end else begin
						op_q <= ttns_pkg::OP_TX0;
					end
					state_q <= ttns_pkg::ST_LOAD;
				end
				ttns_pkg::ST_ABS: begin
					for (int i = 0; i < 3; i++) begin
						nneg_q[i] <= c_q[i][67];
						m_q[i]    <= c_q[i][67] ? 67'(-c_q[i]) : c_q[i][66:0];
					end
					state_q <= ttns_pkg::ST_SHIFT;
				end
				ttns_pkg::ST_SHIFT: begin
					if (|mor_c[66:ttns_pkg::NORM_B]) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else begin
						idx_q     <= '0;
						sum_q     <= '0;
						sq_mode_q <= 1'b1;
						state_q   <= ttns_pkg::ST_LOAD;
					end
				end
				ttns_pkg::ST_SQRT: begin
					if (sq_ge_c) begin
						sq_rem_q <= sq_rem_q - sq_try_c;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					if (sq_bit_q[0])
						state_q <= ttns_pkg::ST_LEN;
				end
				ttns_pkg::ST_LEN: begin
					sq_mode_q <= 1'b0;
					if (len_zero_c) begin
						if (vec_nrm_q) begin
							for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
							area_deg_q <= 1'b1;
							state_q    <= ttns_pkg::ST_DONE;
						end else begin
							tan_q[0]  <= ttns_pkg::UNIT_ONE;
							tan_q[1]  <= '0;
							tan_q[2]  <= '0;
							op_q      <= ttns_pkg::OP_NX0;
							vec_nrm_q <= 1'b1;
							state_q   <= ttns_pkg::ST_LOAD;
						end
					end else begin
						len_q   <= sq_res_q[30:0];
						idx_q   <= '0;
						state_q <= ttns_pkg::ST_DIV;
						drem_q  <= '0;
						dnum_q  <= div_num_c;
						cnt_q   <= ttns_pkg::DIV_LAST;
					end
				end
				ttns_pkg::ST_DIV: begin
					drem_q <= div_ge_c ? (div_r_c - {1'b0, len_q}) : div_r_c;
					quo_q  <= {quo_q[16:0], div_ge_c};
					dnum_q <= dnum_q << 1;
					cnt_q  <= cnt_q - 6'd1;
					if (cnt_q == '0)
						state_q <= ttns_pkg::ST_STORE;
				end
				ttns_pkg::ST_STORE: begin
					if (vec_nrm_q)
						nrm_q[idx_q] <= qval_c;
					else
						tan_q[idx_q] <= qval_c;
					if (idx_q == 2'd2) begin
						if (vec_nrm_q) begin
							area_deg_q <= 1'b0;
							state_q    <= ttns_pkg::ST_DONE;
						end else begin
							op_q      <= ttns_pkg::OP_NX0;
							vec_nrm_q <= 1'b1;
							state_q   <= ttns_pkg::ST_LOAD;
						end
					end else begin
						idx_q   <= idx_q + 2'd1;
						drem_q  <= '0;
						dnum_q  <= div_num_c;
						cnt_q   <= ttns_pkg::DIV_LAST;
						state_q <= ttns_pkg::ST_DIV;
					end
				end
				ttns_pkg::ST_DONE: begin
					if (!o_valid_q || m_axis_tready) begin
						o_data_q  <= {4'b0, nrm_q[2], nrm_q[1], nrm_q[0],
							tan_q[2], tan_q[1], tan_q[0]};
						o_user_q  <= {area_deg_q, uv_deg_q};
						o_valid_q <= 1'b1;
						state_q   <= ttns_pkg::ST_IDLE;
					end
				end
				default: state_q <= ttns_pkg::ST_IDLE;
			endcase
		end
	end

	`TTNS_ASSERT_NXT(a_third_vertex_starts, in_acc && slot_q == 2'd2, state_q == ttns_pkg::ST_LOAD)
	`TTNS_ASSERT_IMP(a_sqrt_bit_onehot, state_q == ttns_pkg::ST_SQRT, $onehot(sq_bit_q))
	`TTNS_ASSERT_IMP(a_slot_reachable, state_q == ttns_pkg::ST_IDLE, slot_q != 2'd3)
	`TTNS_ASSERT_IMP(a_unit_bound, state_q == ttns_pkg::ST_STORE, quo_q <= ttns_pkg::UNIT_ONE)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for triangle_tangent_normal_setup: streams triangle-list vertices, predicts
// each face's tangent, normal and flags, and checks every result. Depends on the block's top.
module tb;

	localparam int IDLE_LIMIT = 20000;
	localparam logic [127:0] NORM_LIMIT = 128'h4000_0000;
	localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

	typedef struct packed {
		logic              uv_deg;
		logic              area_deg;
		logic signed [17:0] tx, ty, tz, nx, ny, nz;
	} face_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;   // pos_x, pos_y, pos_z, tex_u, tex_v
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [111:0] m_axis_tdata;   // tan_x, tan_y, tan_z, nrm_x, nrm_y, nrm_z, pad
	logic [1:0]   m_axis_tuser;   // uv_degenerate, area_degenerate
	logic         cfg_valid;
	logic         cfg_ready;
	logic [46:0]  cfg_data;       // uv_det_threshold

	triangle_tangent_normal_setup u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	logic [143:0] vertex_q[$];
	face_t        face_q[$];
	int           errors, faces_checked, vertices_sent, uv_deg_seen, area_deg_seen, idle_cycles;
	int           burst_left, gap_left, hold_left, stall_mode, mode_left;
	bit           long_hold_done;

	// predictor state
	logic signed [31:0] held_pos[6];
	logic signed [23:0] held_tex[4];
	int                 slot;
	logic [46:0]        det_thr;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Q1.16 unit vector; returns 0 for a zero vector
	function automatic bit unit_q16(input logic signed [127:0] c0, c1, c2,
			output logic signed [17:0] o0, o1, o2);
		logic signed [127:0] c[3];
		logic [127:0]        mg[3];
		logic [127:0]        all;
		bit                  neg[3];
		longint unsigned     m[3], sum, len, q;
		logic signed [17:0]  o[3];
		int                  s;
		c[0] = c0; c[1] = c1; c[2] = c2;
		all = '0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i] < 0;
			mg[i] = neg[i] ? -c[i] : c[i];
			all = all | mg[i];
		end
		s = 0;
		while ((all >> s) >= NORM_LIMIT) s++;
		for (int i = 0; i < 3; i++) begin
			m[i] = 64'(mg[i] >> s);
			sum = sum + m[i] * m[i];
		end
		len = isqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (len == 0) ? 0 : (m[i] * 65536 + len / 2) / len;
			o[i] = neg[i] ? -18'(q) : 18'(q);
		end
		o0 = o[0]; o1 = o[1]; o2 = o[2];
		return len != 0;
	endfunction

	function automatic bit face_setup(input logic [143:0] d, output face_t r);
		logic signed [31:0]  p2[3];
		logic signed [23:0]  t2[2];
		longint              e1[3], e2[3], du1, dv1, du2, dv2, det, dmag;
		logic signed [127:0] c[3], a[3], b[3];
		bit                  det_neg, ok;
		int                  base;
		r = '0;
		if (slot != 2) begin
			base = (slot == 1) ? 1 : 0;
			for (int i = 0; i < 3; i++) held_pos[base * 3 + i] = d[32 * i +: 32];
			held_tex[base * 2] = d[96 +: 24];
			held_tex[base * 2 + 1] = d[120 +: 24];
			slot = base + 1;
			return 0;
		end
		slot = 0;
		for (int i = 0; i < 3; i++) p2[i] = d[32 * i +: 32];
		t2[0] = d[96 +: 24];
		t2[1] = d[120 +: 24];
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(held_pos[3 + i]) - longint'(held_pos[i]);
			e2[i] = longint'(p2[i]) - longint'(held_pos[i]);
		end
		du1 = longint'(held_tex[2]) - longint'(held_tex[0]);
		dv1 = longint'(held_tex[3]) - longint'(held_tex[1]);
		du2 = longint'(t2[0]) - longint'(held_tex[0]);
		dv2 = longint'(t2[1]) - longint'(held_tex[1]);
		det = du1 * dv2 - du2 * dv1;
		det_neg = det < 0;
		dmag = det_neg ? -det : det;
		r.uv_deg = !(dmag > longint'({17'b0, det_thr}));
		r.tx = ONE_Q16;
		if (!r.uv_deg) begin
			for (int i = 0; i < 3; i++) begin
				c[i] = dv2 * e1[i] - dv1 * e2[i];
				if (det_neg) c[i] = -c[i];
			end
			ok = unit_q16(c[0], c[1], c[2], r.tx, r.ty, r.tz);
			if (!ok) r.tx = ONE_Q16;
		end
		for (int i = 0; i < 3; i++) begin
			a[i] = e1[i];
			b[i] = e2[i];
		end
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		r.area_deg = !unit_q16(c[0], c[1], c[2], r.nx, r.ny, r.nz);
		return 1;
	endfunction

	task automatic flag_mismatch(input string field, input logic [17:0] got, exp);
		$display("mismatch on face %0d, %s: got %h, expected %h", faces_checked, field, got, exp);
		errors++;
	endtask

	function automatic logic [143:0] pack_vertex(input logic [31:0] x, y, z,
			input logic [23:0] u, v);
		return {v, u, z, y, x};
	endfunction

	task automatic add_vertex(input logic [143:0] v);
		vertex_q.insert(vertex_q.size(), v);
	endtask

	function automatic logic [31:0] rand_pos(input int kind);
		case (kind)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			default: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [23:0] rand_tex(input int kind);
		case (kind)
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
			default: return ($urandom_range(0, 1) != 0) ? 24'h7f_ffff : 24'h80_0000;
		endcase
	endfunction

	task automatic push_random_triangle();
		logic [143:0] vtx[3];
		int           kind;
		kind = $urandom_range(0, 9);
		kind = (kind < 4) ? 0 : (kind < 8) ? 1 : 2;
		for (int i = 0; i < 3; i++)
			vtx[i] = pack_vertex(rand_pos(kind), rand_pos(kind), rand_pos(kind),
				rand_tex(kind), rand_tex(kind));
		case ($urandom_range(0, 9))
			0: vtx[2][95:0] = vtx[0][95:0];        // coincident positions
			1: vtx[2][143:96] = vtx[1][143:96];    // repeated texcoord
			2: vtx[2][95:0] = vtx[1][95:0];
			default: ;
		endcase
		for (int i = 0; i < 3; i++) add_vertex(vtx[i]);
	endtask

	task automatic write_threshold(input logic [46:0] thr);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= thr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (vertex_q.size() != 0 || s_axis_tvalid || face_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// driver: bursts with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_axis_tvalid) burst_left--;
				if (burst_left <= 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (vertex_q.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= vertex_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: randomly chosen stall patterns plus one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 3000);
			end else begin
				mode_left--;
			end
			if (!long_hold_done && faces_checked == 40) begin
				long_hold_done = 1;
				hold_left = 6000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (stall_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 3) != 0;
					default: m_axis_tready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	// monitor: predicts on each vertex request, checks each result
	always @(posedge clk) begin
		face_t exp_face;
		face_t got;
		if (arst_n) begin
			idle_cycles++;
			if (cfg_valid && cfg_ready) begin
				det_thr = cfg_data;
				idle_cycles = 0;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				idle_cycles = 0;
				got = {m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[17:0], m_axis_tdata[35:18],
					m_axis_tdata[53:36], m_axis_tdata[71:54], m_axis_tdata[89:72],
					m_axis_tdata[107:90]};
				if (face_q.size() == 0) begin
					$display("unexpected result on face %0d", faces_checked);
					errors++;
				end else begin
					exp_face = face_q.pop_front();
					if (got.tx !== exp_face.tx) flag_mismatch("tan_x", got.tx, exp_face.tx);
					if (got.ty !== exp_face.ty) flag_mismatch("tan_y", got.ty, exp_face.ty);
					if (got.tz !== exp_face.tz) flag_mismatch("tan_z", got.tz, exp_face.tz);
					if (got.nx !== exp_face.nx) flag_mismatch("nrm_x", got.nx, exp_face.nx);
					if (got.ny !== exp_face.ny) flag_mismatch("nrm_y", got.ny, exp_face.ny);
					if (got.nz !== exp_face.nz) flag_mismatch("nrm_z", got.nz, exp_face.nz);
					if (got.uv_deg !== exp_face.uv_deg)
						flag_mismatch("uv_degenerate", got.uv_deg, exp_face.uv_deg);
					if (got.area_deg !== exp_face.area_deg)
						flag_mismatch("area_degenerate", got.area_deg, exp_face.area_deg);
					uv_deg_seen += exp_face.uv_deg;
					area_deg_seen += exp_face.area_deg;
				end
				faces_checked++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				idle_cycles = 0;
				vertices_sent++;
				if (face_setup(s_axis_tdata, exp_face)) face_q.insert(face_q.size(), exp_face);
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
				$display("** triangle_tangent_normal_setup: FAILED **");
				$finish;
			end
		end
	end

	localparam logic [31:0] P1 = 32'h0001_0000;
	localparam logic [23:0] T1 = 24'h01_0000;

	initial begin
		logic [46:0] thr_set[5];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0; faces_checked = 0; vertices_sent = 0; uv_deg_seen = 0; area_deg_seen = 0;
		idle_cycles = 0; burst_left = 0; gap_left = 0; hold_left = 0;
		stall_mode = 0; mode_left = 0; long_hold_done = 0;
		for (int i = 0; i < 6; i++) held_pos[i] = '0;
		for (int i = 0; i < 4; i++) held_tex[i] = '0;
		slot = 0;
		det_thr = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed triangles at reset threshold
		add_vertex(pack_vertex(0, 0, 0, 0, 0));     // all zero face
		add_vertex(pack_vertex(0, 0, 0, 0, 0));
		add_vertex(pack_vertex(0, 0, 0, 0, 0));
		add_vertex(pack_vertex(0, 0, 0, 0, 0));     // unit right triangle
		add_vertex(pack_vertex(P1, 0, 0, T1, 0));
		add_vertex(pack_vertex(0, P1, 0, 0, T1));
		add_vertex(pack_vertex(0, 0, 0, 0, 0));     // mirrored uv, negative det
		add_vertex(pack_vertex(P1, 0, 0, T1, 0));
		add_vertex(pack_vertex(0, P1, 0, 0, -T1));
		add_vertex(pack_vertex(P1, P1, P1, 0, 0));  // same point, good uv
		add_vertex(pack_vertex(P1, P1, P1, T1, 0));
		add_vertex(pack_vertex(P1, P1, P1, 0, T1));
		add_vertex(pack_vertex(0, 0, 0, 0, 0));     // collinear positions
		add_vertex(pack_vertex(P1, P1, 0, T1, 0));
		add_vertex(pack_vertex(-P1, -P1, 0, 0, T1));
		add_vertex(pack_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			24'h80_0000, 24'h80_0000));
		add_vertex(pack_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			24'h7f_ffff, 24'h80_0000));
		add_vertex(pack_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			24'h80_0000, 24'h7f_ffff));
		add_vertex(pack_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			24'h7f_ffff, 24'h7f_ffff));
		add_vertex(pack_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			24'h80_0000, 24'h80_0000));
		add_vertex(pack_vertex(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff,
			24'hff_ffff, 24'h00_0001));
		add_vertex(pack_vertex(0, 0, 0, 24'h00_0000, 24'h00_0000));  // tiny det
		add_vertex(pack_vertex(P1, 0, 0, 24'h00_0001, 24'h00_0000));
		add_vertex(pack_vertex(0, P1, 0, 24'h00_0000, 24'h00_0001));
		drain();

		thr_set[0] = 47'h7fff_ffff_ffff;
		thr_set[1] = 47'd1;
		thr_set[2] = 47'h1_0000_0000;
		thr_set[3] = 47'($urandom) << $urandom_range(0, 15);
		thr_set[4] = 47'd0;
		for (int ph = 0; ph < 5; ph++) begin
			write_threshold(thr_set[ph]);
			for (int n = 0; n < 49; n++) push_random_triangle();
			drain();
		end

		$display("covered %0d vertices, %0d faces checked (%0d uv-degenerate, %0d zero-area)",
			vertices_sent, faces_checked, uv_deg_seen, area_deg_seen);
		$display("six threshold settings from 0 to full scale, with random sender and sink stalls");
		if (errors == 0) begin
			$display("** triangle_tangent_normal_setup: PASSED **");
		end else begin
			$display("** triangle_tangent_normal_setup: FAILED **");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/ttns_pkg.sv
src/triangle_tangent_normal_setup.sv
tb/sv/tb.sv
